### hdl/edd_pkg.sv
// Package for the error diffusion dither unit: widths, register indexes,
// the lane control struct and the saturating error-term adder.
// No dependencies.
package edd_pkg;

  localparam int PIX_W          = 8;
  localparam int ERR_W          = 9;
  localparam int NUM_CHAN       = 3;
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int ROW_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam int EDD_MAX_WIDTH  = 2048;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_MAX = 13'd4096;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 2'd2;

  // Diffusion weights, in sixteenths.
  localparam logic [3:0] K_UP_LEFT  = 4'd1;
  localparam logic [3:0] K_UP       = 4'd5;
  localparam logic [3:0] K_UP_RIGHT = 4'd3;
  localparam logic [3:0] K_LEFT     = 4'd7;

  localparam logic [PIX_W-1:0] THRESHOLD = 8'd128;
  localparam logic signed [ERR_W-1:0] PIX_FULL = 9'sd255;

  // Per-pixel control handed from the position logic to every lane.
  typedef struct packed {
    logic accept;
    logic enable;
    logic col_first;
    logic interior;
    logic have_right;
  } edd_lane_ctrl_t;

  // Adds err*k/16, truncated toward zero, to v and clamps to 0..255.
  function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] v,
                                               input logic signed [ERR_W-1:0] e,
                                               input logic [3:0] k);
    logic signed [13:0] prod;
    logic signed [13:0] term;
    logic signed [14:0] sum;
    logic [PIX_W-1:0]   res;
    prod = 14'(e) * 14'($signed({1'b0, k}));
    if (prod[13]) begin
      term = (prod + 14'sd15) >>> 4;
    end else begin
      term = prod >>> 4;
    end
    sum = 15'($signed({1'b0, v})) + 15'(term);
    if (sum < 15'sd0) begin
      res = '0;
    end else if (sum > 15'sd255) begin
      res = 8'd255;
    end else begin
      res = sum[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

### hdl/edd_ifs.sv
// Valid/ready channel interfaces of the dither unit: pixel in, pixel out
// and configuration write. Depends on edd_pkg.
interface edd_pix_in_if;
  import edd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] chan0_in;
  logic [PIX_W-1:0] chan1_in;
  logic [PIX_W-1:0] chan2_in;
  modport source (output valid, chan0_in, chan1_in, chan2_in, input ready);
  modport sink   (input valid, chan0_in, chan1_in, chan2_in, output ready);
endinterface

interface edd_pix_out_if;
  import edd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] chan0_out;
  logic [PIX_W-1:0] chan1_out;
  logic [PIX_W-1:0] chan2_out;
  logic             frame_last;
  modport source (output valid, chan0_out, chan1_out, chan2_out, frame_last, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, frame_last, output ready);
endinterface

interface edd_cfg_if;
  import edd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/edd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module edd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; returns old data on a same-address write.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/edd_lane.sv
// One colour-channel lane: adds the diffused errors, thresholds and keeps
// the above-row window and the left error of its channel. Depends on edd_pkg.
module edd_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  edd_pkg::edd_lane_ctrl_t              ctrl,
  input  logic [edd_pkg::PIX_W-1:0]            pix_in,
  input  logic signed [edd_pkg::ERR_W-1:0]     right_err,
  output logic [edd_pkg::PIX_W-1:0]            pix_out,
  output logic signed [edd_pkg::ERR_W-1:0]     err_out
);
  import edd_pkg::*;

  logic signed [ERR_W-1:0] up_left_r, up_r, left_r;
  logic signed [ERR_W-1:0] up_left, up, left, right;
  logic [PIX_W-1:0]        v1, v2, v3, v4;

  // At the start of a row the window and left error restart from zero.
  always_comb begin
    up_left = ctrl.col_first ? '0 : up_left_r;
    up      = ctrl.col_first ? '0 : up_r;
    left    = ctrl.col_first ? '0 : left_r;
    right   = ctrl.have_right ? right_err : '0;
  end

  // Error terms in order: upper-left, above, upper-right, then left.
  always_comb begin
    v1 = sat_add(pix_in, up_left, K_UP_LEFT);
    v2 = sat_add(v1, up, K_UP);
    v3 = sat_add(v2, right, K_UP_RIGHT);
    v4 = sat_add(v3, left, K_LEFT);
  end

  // When enabled, threshold interior pixels and form their error; edges keep the sum.
  always_comb begin
    pix_out = pix_in;
    err_out = '0;
    if (ctrl.enable) begin
      pix_out = v4;
      if (ctrl.interior) begin
        if (v4 > THRESHOLD) begin
          pix_out = 8'd255;
          err_out = $signed({1'b0, v4}) - PIX_FULL;
        end else begin
          pix_out = '0;
          err_out = $signed({1'b0, v4});
        end
      end
    end
  end

  // Slide the window by one column on every accepted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_left_r <= '0;
      up_r      <= '0;
      left_r    <= '0;
    end else if (ctrl.accept) begin
      up_left_r <= up;
      up_r      <= right;
      left_r    <= err_out;
    end
  end

endmodule

### hdl/error_diffusion_dither_unit.sv
// Error diffusion dither unit, top level: position counters, error line
// buffer with read-ahead, three channel lanes and the output register.
// Depends on edd_pkg, edd_ifs, edd_ram and edd_lane.
//
// Usage: pixels arrive in raster order on in_pix (valid/ready), one
// three-channel pixel per request, and one dithered pixel leaves on out_pix
// for each, with frame_last set on the final pixel of a frame.
// Configuration is written on cfg_wr (index 0 frame width, 1 frame height,
// 2 dither enable) while the block is idle; cfg_wr is always ready.
// An accepted input request is registered directly into the output
// register. Throughput is one pixel per clock while the receiver keeps
// taking outputs: the line buffer is read one pixel ahead, and the
// left-error feedback is registered in each lane for the next pixel.
// A stalled receiver holds the output register; in_pix stays ready while the
// register is empty or being taken in the same cycle, and otherwise waits.
// Reset (rst_n low, synchronous) restores 640 x 480, dithering off, the
// position to the first pixel and clears the error window. The line buffer
// is not cleared: each entry is written in the previous row before it is
// read, so no clearing pass is needed.
module error_diffusion_dither_unit #(
  parameter int MAX_WIDTH = edd_pkg::EDD_MAX_WIDTH
) (
  input logic    clk,
  input logic    rst_n,
  edd_pix_in_if.sink    in_pix,
  edd_pix_out_if.source out_pix,
  edd_cfg_if.sink       cfg_wr
);
  import edd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CMP_W  = (ADDR_W + 1 > FRAME_WIDTH_W) ? ADDR_W + 1 : FRAME_WIDTH_W;
  localparam int WORD_W = NUM_CHAN * ERR_W;

  logic [FRAME_WIDTH_W-1:0]  frame_width_r;
  logic [FRAME_HEIGHT_W-1:0] frame_height_r;
  logic                      dither_enable_r;

  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [CMP_W-1:0]          w_eff, col_inc, rd_sel;
  logic [FRAME_HEIGHT_W-1:0] h_eff, row_inc;
  logic                      last_col, last_row, accept;
  logic [ADDR_W-1:0]         rd_addr;

  logic [WORD_W-1:0] ram_q, wr_word, right_word;
  logic              bypass_r, bypass_nxt;
  logic [WORD_W-1:0] bypass_data_r;

  edd_lane_ctrl_t          lane_ctrl;
  logic [PIX_W-1:0]        lane_in  [NUM_CHAN];
  logic [PIX_W-1:0]        lane_out [NUM_CHAN];
  logic signed [ERR_W-1:0] lane_err [NUM_CHAN];

  logic             out_valid_r;
  logic [PIX_W-1:0] chan0_r, chan1_r, chan2_r;
  logic             frame_last_r;

  // Configuration registers.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      dither_enable_r <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wr.data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wr.data;
        REG_DITHER_ENABLE: dither_enable_r <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register is free or being emptied.
  assign in_pix.ready = !out_valid_r || out_pix.ready;
  assign accept       = in_pix.valid && in_pix.ready;

  // Effective frame size, clamped to what the hardware supports.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(frame_width_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = FRAME_HEIGHT_W'(1);
    end else if (frame_height_r > FRAME_HEIGHT_MAX) begin
      h_eff = FRAME_HEIGHT_MAX;
    end else begin
      h_eff = frame_height_r;
    end
  end

  // Position in the frame and the pixel's role.
  always_comb begin
    col_inc  = CMP_W'(col_r) + CMP_W'(1);
    row_inc  = FRAME_HEIGHT_W'(row_r) + FRAME_HEIGHT_W'(1);
    last_col = col_inc >= w_eff;
    last_row = row_inc >= h_eff;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[ADDR_W-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Read ahead: fetch the upper-right error of the pixel that comes next.
  always_comb begin
    if (accept) begin
      rd_sel = last_col ? CMP_W'(1) : col_inc + CMP_W'(1);
    end else begin
      rd_sel = col_inc;
    end
    rd_addr    = (rd_sel >= CMP_W'(MAX_WIDTH)) ? '0 : rd_sel[ADDR_W-1:0];
    bypass_nxt = accept && (rd_addr == col_r);
  end

  assign wr_word = {lane_err[2], lane_err[1], lane_err[0]};

  edd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Forward a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
    end else begin
      bypass_r <= bypass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bypass_nxt) begin
      bypass_data_r <= wr_word;
    end
  end

  assign right_word = bypass_r ? bypass_data_r : ram_q;

  // Lane control shared by all channels.
  always_comb begin
    lane_ctrl.accept     = accept;
    lane_ctrl.enable     = dither_enable_r;
    lane_ctrl.col_first  = (col_r == '0);
    lane_ctrl.interior   = (col_r != '0) && !last_col && !last_row;
    lane_ctrl.have_right = (row_r != '0) && !last_col;
  end

  assign lane_in[0] = in_pix.chan0_in;
  assign lane_in[1] = in_pix.chan1_in;
  assign lane_in[2] = in_pix.chan2_in;

  // One lane per colour channel.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    edd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl),
      .pix_in    (lane_in[c]),
      .right_err ($signed(right_word[c*ERR_W +: ERR_W])),
      .pix_out   (lane_out[c]),
      .err_out   (lane_err[c])
    );
  end

  // Output register merging the lanes with the end-of-frame flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan0_r      <= lane_out[0];
      chan1_r      <= lane_out[1];
      chan2_r      <= lane_out[2];
      frame_last_r <= last_col && last_row;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.chan0_out  = chan0_r;
  assign out_pix.chan1_out  = chan1_r;
  assign out_pix.chan2_out  = chan2_r;
  assign out_pix.frame_last = frame_last_r;

endmodule
